/* rtl/csv_quoted_field_tokenizer_defines.svh */
// Assertion macros for the CSV tokenizer checker.
// Needs a clock and an active-low reset at the point of use.
`ifndef CSV_QUOTED_FIELD_TOKENIZER_DEFINES_SVH
`define CSV_QUOTED_FIELD_TOKENIZER_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define CSVQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define CSVQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/csvq_pkg.sv */
// Types, character codes and event codes of the CSV tokenizer.
// No dependencies.
`default_nettype none
package csvq_pkg;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [1:0] EV_CHAR       = 2'd0;
    localparam logic [1:0] EV_FIELD_END  = 2'd1;
    localparam logic [1:0] EV_RECORD_END = 2'd2;
    localparam logic [1:0] EV_ERROR      = 2'd3;

    localparam logic [1:0] ERR_NONE            = 2'd0;
    localparam logic [1:0] ERR_STRAY_QUOTE     = 2'd1;
    localparam logic [1:0] ERR_BAD_AFTER_QUOTE = 2'd2;
    localparam logic [1:0] ERR_NO_NEWLINE      = 2'd3;

    typedef enum logic [2:0] {
        MODE_PLAIN       = 3'b001,
        MODE_QUOTED      = 3'b010,
        MODE_AFTER_QUOTE = 3'b100
    } t_mode;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_item;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] field_char;
        logic [1:0] error_code;
    } t_result;

    // Handoff from the parser step to the result register.
    typedef struct packed {
        logic    load;
        t_result result;
    } t_step_out;

endpackage
`default_nettype wire

/* rtl/csvq_stream_if.sv */
// Valid/ready channels for CSV text bytes and tokenizer events.
// Depends on csvq_pkg for nothing but shares its field widths.
`default_nettype none
interface csvq_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface csvq_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [7:0] field_char;
    logic [1:0] error_code;

    modport source (output valid, output event_kind, output field_char,
                    output error_code, input ready);
    modport sink   (input valid, input event_kind, input field_char,
                    input error_code, output ready);
endinterface
`default_nettype wire

/* rtl/csv_quoted_field_tokenizer.sv */
// CSV tokenizer with quoted fields: one byte in, at most one event out.
// An accepted byte passes the input register, then its event the result register; an output stall can hold it between.
// Throughput: one byte per cycle while the output is not stalled; the mode update is a single step per byte.
// Reset (synchronous, active low) empties both registers and returns to plain
// mode at a field start with no error pending.
// Depends on csvq_pkg, csvq_stream_if, csvq_in_reg, csvq_step, csvq_out_reg.
`default_nettype none
module csv_quoted_field_tokenizer
    import csvq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    csvq_text_if.sink     i_text,
    csvq_event_if.source  o_event
);

    t_item     in_item;
    t_item     held_item;
    logic      held_valid;
    logic      out_free;
    logic      fire;
    t_step_out step;
    t_result   result;

    assign in_item.text_byte   = i_text.text_byte;
    assign in_item.end_of_text = i_text.end_of_text;

    // Advance the held byte only when the result register can take its event.
    assign fire = held_valid && out_free;

    csvq_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_text.valid),
        .i_item    (in_item),
        .o_ready   (i_text.ready),
        .i_advance (fire),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    csvq_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (held_item),
        .o_step  (step)
    );

    csvq_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_ready  (o_event.ready),
        .o_free   (out_free),
        .o_valid  (o_event.valid),
        .o_result (result)
    );

    assign o_event.event_kind = result.event_kind;
    assign o_event.field_char = result.field_char;
    assign o_event.error_code = result.error_code;

endmodule
`default_nettype wire

/* rtl/csvq_in_reg.sv */
// Input register of the CSV tokenizer: holds one accepted byte for the parser.
// Depends on csvq_pkg.
`default_nettype none
module csvq_in_reg
    import csvq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_ready,
    input  wire logic  i_advance,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    // Take a new transaction whenever the held byte leaves or none is held; refuse in reset.
    assign o_ready = i_rst_n && (!r_valid || i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

/* rtl/csvq_step.sv */
// Parser step of the CSV tokenizer: mode state and per-byte event decode.
// Depends on csvq_pkg.
`default_nettype none
module csvq_step
    import csvq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    output t_step_out  o_step
);

    t_mode r_mode, n_mode;
    logic  r_start, n_start;
    logic  r_error, n_error;

    logic       has_ev;
    logic [1:0] ev_kind;
    logic [7:0] ev_char;
    logic [1:0] ev_code;
    logic       is_comma_nl;
    logic       last;
    logic [7:0] b;

    assign b           = i_item.text_byte;
    assign last        = i_item.end_of_text;
    assign is_comma_nl = (b == CH_COMMA) || (b == CH_NEWLINE);

    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_error = r_error;
        has_ev  = 1'b0;
        ev_kind = EV_CHAR;
        ev_char = 8'h00;
        ev_code = ERR_NONE;

        if (!r_error) begin
            unique case (r_mode)
                MODE_QUOTED: begin
                    if (b == CH_QUOTE) begin
                        if (last) begin
                            has_ev  = 1'b1;
                            ev_kind = EV_ERROR;
                            ev_code = ERR_BAD_AFTER_QUOTE;
                        end else begin
                            n_mode = MODE_AFTER_QUOTE;
                        end
                    end else begin
                        has_ev  = 1'b1;
                        ev_char = b;
                    end
                end
                MODE_AFTER_QUOTE: begin
                    if (is_comma_nl) begin
                        has_ev  = 1'b1;
                        ev_kind = (b == CH_COMMA) ? EV_FIELD_END : EV_RECORD_END;
                        n_mode  = MODE_PLAIN;
                        n_start = 1'b1;
                    end else if (b == CH_QUOTE) begin
                        has_ev  = 1'b1;
                        ev_char = CH_QUOTE;
                        n_mode  = MODE_QUOTED;
                    end else begin
                        has_ev  = 1'b1;
                        ev_kind = EV_ERROR;
                        ev_code = ERR_BAD_AFTER_QUOTE;
                    end
                end
                default: begin
                    n_mode = MODE_PLAIN;
                    if (b == CH_QUOTE) begin
                        if (r_start) begin
                            n_mode  = MODE_QUOTED;
                            n_start = 1'b0;
                        end else begin
                            has_ev  = 1'b1;
                            ev_kind = EV_ERROR;
                            ev_code = ERR_STRAY_QUOTE;
                        end
                    end else if (is_comma_nl) begin
                        has_ev  = 1'b1;
                        ev_kind = (b == CH_COMMA) ? EV_FIELD_END : EV_RECORD_END;
                        n_start = 1'b1;
                    end else begin
                        has_ev  = 1'b1;
                        ev_char = b;
                        n_start = 1'b0;
                    end
                end
            endcase

            // Text must end in a newline; an earlier error on this byte wins.
            if (last && (b != CH_NEWLINE) && !(has_ev && (ev_kind == EV_ERROR))) begin
                has_ev  = 1'b1;
                ev_kind = EV_ERROR;
                ev_char = 8'h00;
                ev_code = ERR_NO_NEWLINE;
            end

            if (has_ev && (ev_kind == EV_ERROR)) begin
                n_error = 1'b1;
            end
        end

        if (last) begin
            n_mode  = MODE_PLAIN;
            n_start = 1'b1;
            n_error = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PLAIN;
            r_start <= 1'b1;
            r_error <= 1'b0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_error <= n_error;
        end
    end

    assign o_step.load              = i_fire && has_ev;
    assign o_step.result.event_kind = ev_kind;
    assign o_step.result.field_char = ev_char;
    assign o_step.result.error_code = ev_code;

endmodule
`default_nettype wire

/* rtl/csvq_out_reg.sv */
// Result register of the CSV tokenizer: holds one event until it is taken.
// Depends on csvq_pkg.
`default_nettype none
module csvq_out_reg
    import csvq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_step_out i_step,
    input  wire logic      i_ready,
    output logic           o_free,
    output logic           o_valid,
    output t_result        o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_step.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_step.load) begin
            r_result <= i_step.result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

/* rtl/csvq_checker.sv */
// Port-level checks of the CSV tokenizer output, bound to the top level.
// Depends on csvq_pkg and csv_quoted_field_tokenizer_defines.svh.
`default_nettype none
`include "csv_quoted_field_tokenizer_defines.svh"
module csvq_checker
    import csvq_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] i_event_kind,
    input wire logic [7:0] i_field_char,
    input wire logic [1:0] i_error_code
);

    `CSVQ_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "output transaction dropped while stalled")
    `CSVQ_ASSERT_NOW(a_code_only_on_error, i_clk, i_rst_n, i_out_valid && (i_event_kind != EV_ERROR), i_error_code == ERR_NONE, "error code set on a non-error event")
    `CSVQ_ASSERT_NOW(a_error_has_code, i_clk, i_rst_n, i_out_valid && (i_event_kind == EV_ERROR), i_error_code != ERR_NONE, "error event without a code")
    `CSVQ_ASSERT_NOW(a_char_only_on_char, i_clk, i_rst_n, i_out_valid && (i_event_kind != EV_CHAR), i_field_char == 8'h00, "character set on a non-character event")

endmodule

bind csv_quoted_field_tokenizer csvq_checker u_csvq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_event.valid),
    .i_out_ready  (o_event.ready),
    .i_event_kind (o_event.event_kind),
    .i_field_char (o_event.field_char),
    .i_error_code (o_event.error_code)
);
`default_nettype wire
